/* hdl/sync_length_xor_deframer_core_assert.svh */
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the top-level module, which checks its own logic.
`ifndef SYNC_LENGTH_XOR_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_CORE_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define SLD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked property that also holds while reset is asserted.
`define SLD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* hdl/sld_pkg.sv */
// Shared types and constants of the sync/length/XOR deframer.
// No dependencies; imported by every deframer module.
package sld_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [ByteW-1:0] FirstSyncRst  = 8'hA5;
  localparam logic [ByteW-1:0] SecondSyncRst = 8'h5A;
  localparam logic [ByteW-1:0] MaxLengthRst  = 8'd160;
  localparam logic [ByteW-1:0] CharLf        = 8'h0A;
  localparam logic [ByteW-1:0] CharCr        = 8'h0D;

  localparam logic [CfgIdxW-1:0] CfgFirstSync  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondSync = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLength  = 8'd2;

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_TOOLONG = 3'd3,
    KIND_LBYTE   = 3'd4,
    KIND_LEND    = 3'd5,
    KIND_LOVER   = 3'd6
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] first_sync;
    logic [ByteW-1:0] second_sync;
    logic [ByteW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] packet_length;
    logic [ByteW-1:0] packet_type;
    logic [ByteW-1:0] data_byte;
  } result_t;

endpackage

/* hdl/sld_cfg_regs.sv */
// Configuration registers of the deframer: sync bytes and length limit.
// Depends on sld_pkg.
module sld_cfg_regs
  import sld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      if (cfg_index_i == CfgFirstSync) begin
        cfg_d.first_sync = cfg_data_i;
      end else if (cfg_index_i == CfgSecondSync) begin
        cfg_d.second_sync = cfg_data_i;
      end else if (cfg_index_i == CfgMaxLength) begin
        cfg_d.max_length = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sync  <= FirstSyncRst;
      cfg_q.second_sync <= SecondSyncRst;
      cfg_q.max_length  <= MaxLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sld_parser.sv */
// Frame and text-line parser: state registers and the per-byte step logic.
// Depends on sld_pkg.
module sld_parser
  import sld_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] fill_q, fill_d;
  logic             in_frame;
  logic [ByteW-1:0] count_inc;

  assign in_frame  = (phase_q != PH_SYNC0) || (byte_i == cfg_i.first_sync);
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    len_d       = len_q;
    count_d     = count_q;
    xor_d       = xor_q;
    fill_d      = fill_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (in_frame) begin
      unique case (phase_q)
        PH_SYNC0: begin
          phase_d = PH_SYNC1;
        end
        PH_SYNC1: begin
          phase_d = (byte_i == cfg_i.second_sync) ? PH_TYPE : PH_SYNC0;
        end
        PH_TYPE: begin
          type_d  = byte_i;
          xor_d   = byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = byte_i;
          count_d = '0;
          xor_d   = xor_q ^ byte_i;
          if (byte_i > cfg_i.max_length) begin
            phase_d             = PH_SYNC0;
            res_valid_o         = 1'b1;
            res_o.kind          = KIND_TOOLONG;
            res_o.packet_type   = type_q;
            res_o.packet_length = byte_i;
          end else begin
            phase_d = (byte_i == '0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          xor_d   = xor_q ^ byte_i;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_PAYLOAD;
          res_o.data_byte     = byte_i;
          res_o.packet_type   = type_q;
          res_o.packet_length = len_q;
          res_o.byte_index    = count_q;
        end
        default: begin
          phase_d             = PH_SYNC0;
          res_valid_o         = 1'b1;
          res_o.kind          = (byte_i == xor_q) ? KIND_GOOD : KIND_BAD;
          res_o.packet_type   = type_q;
          res_o.packet_length = len_q;
        end
      endcase
    end else begin
      phase_d = PH_SYNC0;
      if (byte_i == CharCr) begin
        res_valid_o = 1'b0;
      end else if (byte_i == CharLf) begin
        fill_d              = '0;
        res_valid_o         = 1'b1;
        res_o.kind          = KIND_LEND;
        res_o.packet_length = fill_q;
        res_o.byte_index    = fill_q;
      end else if (fill_q < cfg_i.max_length) begin
        fill_d           = fill_q + 8'd1;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_LBYTE;
        res_o.data_byte  = byte_i;
        res_o.byte_index = fill_q;
      end else begin
        fill_d      = '0;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_LOVER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC0;
      type_q  <= '0;
      len_q   <= '0;
      count_q <= '0;
      xor_q   <= '0;
      fill_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      fill_q  <= fill_d;
    end
  end

endmodule

/* hdl/sld_out_reg.sv */
// Result register of the deframer, holding one result until it is taken.
// Depends on sld_pkg.
module sld_out_reg
  import sld_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hdl/sync_length_xor_deframer_core.sv */
// Top level of the sync/length/XOR-checksum deframer with text-line channel.
// Depends on sld_pkg, sld_cfg_regs, sld_parser, sld_out_reg and the assert header.
//
// The block takes one received byte per cycle while its output is not
// stalled and gives at most one result per byte. A byte lands in an input
// register, is parsed against the parser state there, and its result, if
// any, is loaded into the result register as the byte leaves. The parser
// state, a byte wide, updates once per parsed byte, which sets the rate of
// one byte per clock. When the result register holds an untaken result,
// the input register still takes one byte, then stalls. Configuration
// writes are accepted in every cycle and take effect on the next parsed byte.
`include "sync_length_xor_deframer_core_assert.svh"

module sync_length_xor_deframer_core
  import sld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [7:0] data_byte, [15:8] packet_type, [23:16] packet_length, [31:24] byte_index
  output logic [31:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,   // [2:0] kind
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             adv;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  sld_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign adv           = in_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sld_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  sld_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_i    (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .res_o      (out_res)
  );

  assign m_axis_tdata = {out_res.byte_index, out_res.packet_length,
                         out_res.packet_type, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

  `SLD_ASSERT_ALWAYS(a_idle_in_reset, clk_i, (!rst_ni) |-> (!m_axis_tvalid && !in_valid_q))
  `SLD_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (in_valid_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
  `SLD_ASSERT(a_result_from_byte, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_valid_q))
  `SLD_ASSERT(a_line_no_type, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser == KIND_LBYTE || m_axis_tuser == KIND_LEND || m_axis_tuser == KIND_LOVER)) |-> (m_axis_tdata[15:8] == 8'd0))
  `SLD_ASSERT(a_data_only_bytes, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD && m_axis_tuser != KIND_LBYTE) |-> (m_axis_tdata[7:0] == 8'd0))

endmodule
